[hw/rtl/heus_pkg.sv]
`default_nettype none

package heus_pkg;

  // Depth of the job queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Characters that take part in the five entities.
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Match state: which entity prefix is currently held, one-hot.
  typedef enum logic [15:0] {
    P_NONE = 16'h0001,  // nothing held
    P_AMP  = 16'h0002,  // "&"
    P_A    = 16'h0004,  // "&a"
    P_AM   = 16'h0008,  // "&am"
    P_AMPP = 16'h0010,  // "&amp"
    P_L    = 16'h0020,  // "&l"
    P_LT   = 16'h0040,  // "&lt"
    P_G    = 16'h0080,  // "&g"
    P_GT   = 16'h0100,  // "&gt"
    P_Q    = 16'h0200,  // "&q"
    P_QU   = 16'h0400,  // "&qu"
    P_QUO  = 16'h0800,  // "&quo"
    P_QUOT = 16'h1000,  // "&quot"
    P_H    = 16'h2000,  // "&#"
    P_H3   = 16'h4000,  // "&#3"
    P_H39  = 16'h8000   // "&#39"
  } pfx_e;

  // Input and result words.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_end;
    logic       out_string_end;
  } out_word_t;

  // One job for the back end: the held prefix text, then an optional tail byte.
  typedef struct packed {
    pfx_e       pfx;
    logic       has_tail;
    logic [7:0] tail;
    logic       last;
  } job_t;

  // Result of checking for a completed entity.
  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } ent_t;

  // Prefix that the held prefix plus one byte extends to, P_NONE if none.
  function automatic pfx_e next_prefix(pfx_e s, logic [7:0] b);
    pfx_e r;
    r = P_NONE;
    case (s)
      P_NONE: if (b == CH_AMP) r = P_AMP;
      P_AMP: begin
        if (b == CH_A) r = P_A;
        else if (b == CH_L) r = P_L;
        else if (b == CH_G) r = P_G;
        else if (b == CH_Q) r = P_Q;
        else if (b == CH_HASH) r = P_H;
      end
      P_A:   if (b == CH_M) r = P_AM;
      P_AM:  if (b == CH_P) r = P_AMPP;
      P_L:   if (b == CH_T) r = P_LT;
      P_G:   if (b == CH_T) r = P_GT;
      P_Q:   if (b == CH_U) r = P_QU;
      P_QU:  if (b == CH_O) r = P_QUO;
      P_QUO: if (b == CH_T) r = P_QUOT;
      P_H:   if (b == CH_3) r = P_H3;
      P_H3:  if (b == CH_9) r = P_H39;
      default: r = P_NONE;
    endcase
    return r;
  endfunction

  // Completed entity for the held prefix plus one byte.
  function automatic ent_t entity_done(pfx_e s, logic [7:0] b);
    ent_t r;
    r.hit = 1'b0;
    r.ch  = CH_NUL;
    if (b == CH_SEMI) begin
      case (s)
        P_AMPP: begin r.hit = 1'b1; r.ch = CH_AMP;   end
        P_LT:   begin r.hit = 1'b1; r.ch = CH_LT;    end
        P_GT:   begin r.hit = 1'b1; r.ch = CH_GT;    end
        P_QUOT: begin r.hit = 1'b1; r.ch = CH_QUOTE; end
        P_H39:  begin r.hit = 1'b1; r.ch = CH_APOS;  end
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Number of bytes a prefix holds.
  function automatic logic [2:0] prefix_len(pfx_e s);
    logic [2:0] n;
    case (s)
      P_NONE:                        n = 3'd0;
      P_AMP:                         n = 3'd1;
      P_A, P_L, P_G, P_Q, P_H:       n = 3'd2;
      P_AM, P_LT, P_GT, P_QU, P_H3:  n = 3'd3;
      P_AMPP, P_QUO, P_H39:          n = 3'd4;
      P_QUOT:                        n = 3'd5;
      default:                       n = 3'd0;
    endcase
    return n;
  endfunction

  // Prefix text, first byte in the low bits.
  function automatic logic [47:0] prefix_text(pfx_e s);
    logic [47:0] t;
    case (s)
      P_AMP:  t = {CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_AMP};
      P_A:    t = {CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_A, CH_AMP};
      P_AM:   t = {CH_NUL, CH_NUL, CH_NUL, CH_M, CH_A, CH_AMP};
      P_AMPP: t = {CH_NUL, CH_NUL, CH_P, CH_M, CH_A, CH_AMP};
      P_L:    t = {CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_L, CH_AMP};
      P_LT:   t = {CH_NUL, CH_NUL, CH_NUL, CH_T, CH_L, CH_AMP};
      P_G:    t = {CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_G, CH_AMP};
      P_GT:   t = {CH_NUL, CH_NUL, CH_NUL, CH_T, CH_G, CH_AMP};
      P_Q:    t = {CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_Q, CH_AMP};
      P_QU:   t = {CH_NUL, CH_NUL, CH_NUL, CH_U, CH_Q, CH_AMP};
      P_QUO:  t = {CH_NUL, CH_NUL, CH_O, CH_U, CH_Q, CH_AMP};
      P_QUOT: t = {CH_NUL, CH_T, CH_O, CH_U, CH_Q, CH_AMP};
      P_H:    t = {CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_HASH, CH_AMP};
      P_H3:   t = {CH_NUL, CH_NUL, CH_NUL, CH_3, CH_HASH, CH_AMP};
      P_H39:  t = {CH_NUL, CH_NUL, CH_9, CH_3, CH_HASH, CH_AMP};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/heus_front.sv]
`default_nettype none

module heus_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire heus_pkg::in_word_t in_i,
  output heus_pkg::job_t          job_o,
  output logic                    job_push_o
);
  import heus_pkg::*;

  pfx_e       state_q, state_d;
  pfx_e       ext;
  ent_t       ent;
  logic [7:0] b;
  logic       last;

  assign b    = in_i.in_byte;
  assign last = in_i.in_last;
  assign ext  = next_prefix(state_q, b);
  assign ent  = entity_done(state_q, b);

  // Classify the byte against the held prefix and build the job.
  always_comb begin
    state_d        = state_q;
    job_o.pfx      = P_NONE;
    job_o.has_tail = 1'b0;
    job_o.tail     = b;
    job_o.last     = last;
    job_push_o     = 1'b0;
    if (ext != P_NONE) begin
      // The prefix grows; on the final byte the grown prefix is flushed.
      job_o.pfx  = ext;
      job_push_o = accept_i && last;
      state_d    = last ? P_NONE : ext;
    end else if (ent.hit) begin
      job_o.has_tail = 1'b1;
      job_o.tail     = ent.ch;
      job_push_o     = accept_i;
      state_d        = P_NONE;
    end else begin
      // Broken match: held prefix goes out verbatim, then the byte or a new prefix.
      job_o.pfx  = state_q;
      job_push_o = accept_i;
      if (b == CH_AMP && !last) begin
        state_d = P_AMP;
      end else begin
        job_o.has_tail = 1'b1;
        state_d        = P_NONE;
      end
    end
  end

  // Match state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_NONE;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  // A string never leaves a prefix held behind it.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_i.in_last |=> state_q == P_NONE)
    else $error("prefix held after final byte");

  // Every pushed job carries at least one byte.
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o |-> (job_o.has_tail || job_o.pfx != P_NONE))
    else $error("empty job pushed");
`endif

endmodule

`default_nettype wire

[hw/rtl/heus_queue.sv]
`default_nettype none

module heus_queue #(
  parameter int unsigned Depth = heus_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire heus_pkg::job_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output heus_pkg::job_t      data_o,
  output logic                empty_o
);
  import heus_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  // The fill count stays within the storage.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

[hw/rtl/heus_back.sv]
`default_nettype none

module heus_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire heus_pkg::job_t job_i,
  input  wire logic           job_valid_i,
  output logic                job_pop_o,
  output heus_pkg::out_word_t out_o,
  output logic                empty_o,
  input  wire logic           pop_i
);
  import heus_pkg::*;

  logic [2:0]  idx_q, idx_d;
  out_word_t   out_q, out_d;
  logic        out_valid_q;
  logic [2:0]  plen, total;
  logic [47:0] ptxt;
  logic        run_end, advance;

  assign plen    = prefix_len(job_i.pfx);
  assign ptxt    = prefix_text(job_i.pfx);
  assign total   = plen + {2'b00, job_i.has_tail};
  assign run_end = ((idx_q + 3'd1) == total);
  assign advance = job_valid_i && (!out_valid_q || pop_i);

  // Pick the next word of the head job: prefix bytes first, then the tail.
  always_comb begin
    out_d.out_byte       = (idx_q < plen) ? ptxt[{idx_q, 3'b000} +: 8] : job_i.tail;
    out_d.out_run_end    = run_end;
    out_d.out_string_end = run_end && job_i.last;
    idx_d                = run_end ? 3'd0 : idx_q + 3'd1;
  end

  assign job_pop_o = advance && run_end;
  assign out_o     = out_q;
  assign empty_o   = !out_valid_q;

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Byte index within the job and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        idx_q       <= idx_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  // The end of a string is always the end of its run.
  a_str_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && out_o.out_string_end |-> out_o.out_run_end)
    else $error("string end without run end");

  // The index stays below the length of the head job.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q < total)
    else $error("job index past job length");
`endif

endmodule

`default_nettype wire

[hw/rtl/html_entity_unescape_stream.sv]
`default_nettype none

// Streaming decoder for &amp; &lt; &gt; &quot; &#39;. One byte word is taken per
// cycle whenever the job queue has room; the front end matches it against the
// held entity prefix in that same cycle and queues a job; a byte that only
// extends a prefix queues nothing unless it ends the string. The back end
// emits a job's words in order, 1 to 6 of them (the held prefix plus one byte);
// a result passes the job queue and then the back end's output register. The
// output sequencer in the back end sets the sustained rate: one result word per
// cycle while the receiver pops, one input byte per cycle for ordinary text.
module html_entity_unescape_stream #(
  parameter int unsigned QueueDepth = heus_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire heus_pkg::in_word_t  in_word_i,
  input  wire logic                push,
  output logic                     full,
  output heus_pkg::out_word_t      out_word_o,
  output logic                     empty,
  input  wire logic                pop
);
  import heus_pkg::*;

  job_t front_job, head_job;
  logic front_push, q_full, q_empty, q_pop;

  assign full = q_full;

  // Front end: match state and classification.
  heus_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (push && !q_full),
    .in_i       (in_word_i),
    .job_o      (front_job),
    .job_push_o (front_push)
  );

  // Job queue between the two ends.
  heus_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (head_job),
    .empty_o (q_empty)
  );

  // Back end: emits the words of each job.
  heus_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (!q_empty),
    .job_pop_o   (q_pop),
    .out_o       (out_word_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

`default_nettype wire

[verif/html_entity_unescape_stream_chk.sv]
`timescale 1ns / 100ps

// Watches both word channels of the entity decoder. It predicts the decoded
// words for every accepted input word and compares the output words in order.
module html_entity_unescape_stream_chk (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  heus_pkg::in_word_t  in_word_i,
  input  wire logic           push_i,
  input  wire logic           full_i,
  input  heus_pkg::out_word_t out_word_i,
  input  wire logic           empty_i,
  input  wire logic           pop_i,
  output int                  err_cnt_o,
  output int                  pending_o,
  output int                  words_o,
  output int                  entities_o
);

  localparam int NUM_ENT = 5;

  // Bytes of the entity prefix currently held back, first byte at index 0.
  logic [7:0] held_q[$];
  // Output words still to come, oldest first.
  heus_pkg::out_word_t decoded_q[$];

  initial begin
    err_cnt_o  = 0;
    pending_o  = 0;
    words_o    = 0;
    entities_o = 0;
  end

  // Text of one entity and the character it decodes to.
  function automatic string entity_text(input int k, output logic [7:0] ch);
    case (k)
      0:       begin ch = heus_pkg::CH_AMP;   return "&amp;";  end
      1:       begin ch = heus_pkg::CH_LT;    return "&lt;";   end
      2:       begin ch = heus_pkg::CH_GT;    return "&gt;";   end
      3:       begin ch = heus_pkg::CH_QUOTE; return "&quot;"; end
      default: begin ch = heus_pkg::CH_APOS;  return "&#39;";  end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt_o++;
  endtask

  // Works out the output words that one input word causes and queues them.
  task automatic decode_byte(input heus_pkg::in_word_t w);
    logic [7:0]          cand[$];
    logic [7:0]          outs[$];
    logic [7:0]          ch;
    logic [7:0]          hit_ch;
    string               ent;
    bit                  agree;
    bit                  is_prefix;
    bit                  hit;
    int                  k;
    int                  i;
    heus_pkg::out_word_t r;

    cand = held_q;
    cand.push_back(w.in_byte);
    is_prefix = 1'b0;
    hit       = 1'b0;
    hit_ch    = heus_pkg::CH_NUL;

    // Held bytes plus the new byte either begin an entity, complete one, or
    // match nothing.
    for (k = 0; k < NUM_ENT; k++) begin
      ent   = entity_text(k, ch);
      agree = (cand.size() <= ent.len());
      for (i = 0; agree && i < cand.size(); i++) begin
        if (cand[i] != ent[i]) agree = 1'b0;
      end
      if (agree && cand.size() == ent.len()) begin
        hit    = 1'b1;
        hit_ch = ch;
      end else if (agree) begin
        is_prefix = 1'b1;
      end
    end

    if (is_prefix) begin
      held_q = cand;
    end else if (hit) begin
      outs.push_back(hit_ch);
      held_q.delete();
      entities_o++;
    end else begin
      // Broken match: the held text goes out as it is, then the byte starts
      // over from idle.
      foreach (held_q[j]) outs.push_back(held_q[j]);
      held_q.delete();
      if (w.in_byte == heus_pkg::CH_AMP) held_q.push_back(w.in_byte);
      else outs.push_back(w.in_byte);
    end

    // The final byte of a string flushes whatever is still held.
    if (w.in_last) begin
      foreach (held_q[j]) outs.push_back(held_q[j]);
      held_q.delete();
    end

    for (i = 0; i < outs.size(); i++) begin
      r.out_byte       = outs[i];
      r.out_run_end    = (i == outs.size() - 1);
      r.out_string_end = (i == outs.size() - 1) && w.in_last;
      decoded_q.push_back(r);
    end
  endtask

  // Compares one output word with the oldest prediction.
  task automatic check_word(input heus_pkg::out_word_t got);
    heus_pkg::out_word_t exp_w;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word byte=%02h", got.out_byte));
      return;
    end
    exp_w = decoded_q.pop_front();
    if (got.out_byte !== exp_w.out_byte)
      report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, exp_w.out_byte));
    if (got.out_run_end !== exp_w.out_run_end)
      report_mismatch($sformatf("out_run_end %b, want %b (byte %02h)",
                                got.out_run_end, exp_w.out_run_end, exp_w.out_byte));
    if (got.out_string_end !== exp_w.out_string_end)
      report_mismatch($sformatf("out_string_end %b, want %b (byte %02h)",
                                got.out_string_end, exp_w.out_string_end, exp_w.out_byte));
    words_o++;
  endtask

  // Prediction runs before the compare so that a word taken and a word given
  // at the same edge are handled in stream order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_i) decode_byte(in_word_i);
      if (pop_i && !empty_i) check_word(out_word_i);
      pending_o = decoded_q.size();
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

// Drives byte strings into the entity decoder and pulls decoded words out, with
// random gaps on both sides; the checker beside the block judges every word.
module tb;

  localparam int NUM_ITEMS   = 310;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 50;
  localparam int TAIL_CYCLES = 64;
  localparam int CYCLE_LIMIT = 500000;

  logic                clk_i;
  logic                rst_ni;
  heus_pkg::in_word_t  in_word;
  logic                push;
  logic                full;
  heus_pkg::out_word_t out_word;
  logic                empty;
  logic                pop;

  int err_cnt;
  int pending;
  int words_seen;
  int entities_seen;

  int    n_items;
  int    n_strings;
  int    stall_cycles;
  int    cycle_cnt;
  int    n_popped;
  bit    rx_burst;
  string ent_names[5];

  html_entity_unescape_stream u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word),
    .push       (push),
    .full       (full),
    .out_word_o (out_word),
    .empty      (empty),
    .pop        (pop)
  );

  html_entity_unescape_stream_chk u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word),
    .push_i     (push),
    .full_i     (full),
    .out_word_i (out_word),
    .empty_i    (empty),
    .pop_i      (pop),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .words_o    (words_seen),
    .entities_o (entities_seen)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Cycle count for the run limit, plus how often the input was held back.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni && push && full) stall_cycles++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // Idle length: mostly none, sometimes a few cycles, now and then a long one.
  function automatic int idle_len(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Any byte half the time, otherwise one of the characters entities are made of.
  function automatic logic [7:0] pick_byte();
    string pool;
    pool = "amplgtquo#39;&";
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // Offers one word and holds it until the block takes it.
  task automatic send_word(input logic [7:0] b, input bit last, input bit burst);
    int gap;
    gap = idle_len(burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_word <= '{in_byte: b, in_last: last};
    push    <= 1'b1;
    do @(posedge clk_i); while (full);
    n_items++;
    if (last) n_strings++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit last);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i], last && (i == s.len() - 1), 1'b0);
  endtask

  // Receiver: random pops, bursts without gaps, and one long hold-off that
  // lets the block fill up while the sender keeps offering words.
  initial begin
    int  gap;
    bit  held;
    held = 1'b0;
    rx_burst = 1'b0;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = idle_len(rx_burst);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      n_popped++;
      @(negedge clk_i);
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      if (!held && n_popped >= HOLD_AFTER) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [7:0] text_q[$];
    string      ent;
    int         n_seg;
    int         kind;
    int         cut;
    int         i;
    bit         burst;

    ent_names[0] = "&amp;";
    ent_names[1] = "&lt;";
    ent_names[2] = "&gt;";
    ent_names[3] = "&quot;";
    ent_names[4] = "&#39;";
    n_items      = 0;
    n_strings    = 0;
    stall_cycles = 0;
    cycle_cnt    = 0;
    n_popped     = 0;
    rst_ni       = 1'b0;
    push         = 1'b0;
    in_word      = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: every entity with the string ending on the last semicolon, a
    // zero byte, a second ampersand breaking a held one, an all-ones byte
    // breaking a match at string end, and a prefix still held at string end.
    send_text("&amp;&lt;&gt;&quot;&#39;", 1'b1);
    send_word(heus_pkg::CH_NUL, 1'b0, 1'b0);
    send_text("&&", 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_text("&q", 1'b1);

    // Random strings built from whole entities, cut-off entities followed by a
    // stray byte, lone ampersands and plain bytes; some strings end mid-entity.
    while (n_items < NUM_ITEMS) begin
      text_q.delete();
      n_seg = $urandom_range(1, 8);
      repeat (n_seg) begin
        kind = $urandom_range(0, 9);
        ent  = ent_names[$urandom_range(0, 4)];
        case (kind)
          0, 1, 2: begin
            for (i = 0; i < ent.len(); i++) text_q.push_back(ent[i]);
          end
          3, 4: begin
            cut = $urandom_range(1, ent.len() - 1);
            for (i = 0; i < cut; i++) text_q.push_back(ent[i]);
            text_q.push_back(pick_byte());
          end
          5: text_q.push_back(heus_pkg::CH_AMP);
          default: repeat ($urandom_range(1, 4)) text_q.push_back(pick_byte());
        endcase
      end
      if ($urandom_range(0, 4) == 0 && text_q.size() > 1)
        repeat ($urandom_range(1, text_q.size() - 1)) void'(text_q.pop_back());
      burst = ($urandom_range(0, 3) == 0);
      for (i = 0; i < text_q.size(); i++)
        send_word(text_q[i], i == text_q.size() - 1, burst);
    end
    push <= 1'b0;

    // Drain, then give the block time to show any stray word.
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings; checked %0d decoded words, %0d entities.",
             n_items, n_strings, words_seen, entities_seen);
    $display("Input was held back by a full block on %0d cycles.", stall_cycles);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
